@@ hw/rtl/hscg_pkg.sv @@
// Package for the heading speed command generator: types, constants and shape tables.
`default_nettype none

package hscg_pkg;

  // Angle format and table geometry.
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int LUT_DEPTH       = 256;
  localparam int IDX_W           = $clog2(LUT_DEPTH);

  // Field and datapath widths.
  localparam int ANGLE_W  = 16;
  localparam int REG_W    = 16;
  localparam int WRAP_W   = 24;
  localparam int MAG_W    = 17;
  localparam int ARG_W    = MAG_W + REG_W;
  localparam int GAUSS_W  = 17;
  localparam int SIG_W    = 15;
  localparam int LIN_P_W  = REG_W + GAUSS_W;
  localparam int TURN_P_W = REG_W + SIG_W;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_RECIP_SPEED_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECIP_TURN_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LINEAR_SPEED  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TURN_RATE     = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [REG_W-1:0] RECIP_SPEED_WIDTH_RST = 16'd4096;
  localparam logic [REG_W-1:0] RECIP_TURN_WIDTH_RST  = 16'd4096;
  localparam logic [REG_W-1:0] MAX_LINEAR_SPEED_RST  = 16'd32768;
  localparam logic [REG_W-1:0] MAX_TURN_RATE_RST     = 16'd32768;

  // Fixed-point pi and two pi in the angle format, rounded to nearest.
  localparam logic [63:0] PI_Q30     = 64'd3373259426;
  localparam logic [63:0] ONE_Q30    = 64'd1 << 30;
  localparam logic [63:0] HALF_Q30   = 64'd1 << 29;
  localparam logic [63:0] PI_FIX     =
    (PI_Q30 + (64'd1 << (29 - ANGLE_FRAC_BITS))) >> (30 - ANGLE_FRAC_BITS);
  localparam logic [63:0] TWO_PI_FIX =
    (PI_Q30 + (64'd1 << (28 - ANGLE_FRAC_BITS))) >> (29 - ANGLE_FRAC_BITS);

  // Table ranges and the shifts that turn a scaled error into a table index.
  localparam int GAUSS_RANGE = 4;
  localparam int SIG_RANGE   = 8;
  localparam int GAUSS_SHIFT =
    ANGLE_FRAC_BITS + 12 + $clog2(GAUSS_RANGE) - $clog2(LUT_DEPTH);
  localparam int SIG_SHIFT   =
    ANGLE_FRAC_BITS + 12 + $clog2(SIG_RANGE) - $clog2(LUT_DEPTH);

  // Request and result payloads.
  typedef struct packed {
    logic signed [ANGLE_W-1:0] target_angle;
    logic signed [ANGLE_W-1:0] heading;
  } cmd_t;

  typedef struct packed {
    logic        [15:0] linear_speed;
    logic signed [15:0] turn_rate;
  } result_t;

  typedef logic [GAUSS_W-1:0] gauss_lut_t [LUT_DEPTH];
  typedef logic [SIG_W-1:0]   sig_lut_t   [LUT_DEPTH];

  // Unsigned long division by shift and subtract; used only to build the tables.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // exp(-y) for y in Q30: fourth-order series on y/256, then squared eight times.
  function automatic logic [63:0] exp_neg_q30(input logic [63:0] y);
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] u3;
    logic [63:0] u4;
    logic [63:0] r;
    u  = y >> 8;
    u2 = (u * u + HALF_Q30) >> 30;
    u3 = (u2 * u + HALF_Q30) >> 30;
    u4 = (u3 * u + HALF_Q30) >> 30;
    r  = ONE_Q30 - u + (u2 >> 1) - udiv64(u3, 64'd6) + udiv64(u4, 64'd24);
    for (int k = 0; k < 8; k++) begin
      r = (r * r + HALF_Q30) >> 30;
    end
    return r;
  endfunction

  // Gaussian table: exp(-(4i/depth)^2) in Q16.
  function automatic gauss_lut_t gauss_table();
    gauss_lut_t  tab;
    logic [63:0] ii;
    logic [63:0] y;
    for (int i = 0; i < LUT_DEPTH; i++) begin
      ii = 64'(i);
      y  = ((64'(GAUSS_RANGE * GAUSS_RANGE) * ii * ii) << 30) >> (2 * IDX_W);
      tab[i] = GAUSS_W'((exp_neg_q30(y) + (64'd1 << 13)) >> 14);
    end
    return tab;
  endfunction

  // Sigmoid table: 1/(1+exp(-8j/depth)) - 0.5 in Q16, held below one half.
  function automatic sig_lut_t sig_table();
    sig_lut_t    tab;
    logic [63:0] y;
    logic [63:0] e;
    logic [63:0] sig;
    logic [63:0] s;
    for (int j = 0; j < LUT_DEPTH; j++) begin
      y   = ((64'(SIG_RANGE) * 64'(j)) << 30) >> IDX_W;
      e   = exp_neg_q30(y);
      sig = udiv64(64'd1 << 60, ONE_Q30 + e);
      s   = (sig > (ONE_Q30 >> 1)) ? sig - (ONE_Q30 >> 1) : 64'd0;
      s   = (s + (64'd1 << 13)) >> 14;
      tab[j] = (s > 64'd32767) ? SIG_W'(32767) : SIG_W'(s);
    end
    return tab;
  endfunction

  localparam gauss_lut_t GAUSS_LUT = gauss_table();
  localparam sig_lut_t   SIG_LUT   = sig_table();

endpackage

`default_nettype wire

@@ hw/rtl/heading_speed_command_generator_top.sv @@
// Top level of the heading speed command generator: a five-stage pipeline.
//
//  Channel   Signals                              Handshake
//  request   start, busy, cmd                     taken when start is high and busy low
//  result    done, result                         shown for one cycle, cannot be held off
//  config    cfg_write, cfg_index, cfg_data       written when cfg_write is high
//
// A request passes through five register stages from acceptance to its done
// strobe: wrap, shape scaling multiply, table lookup, speed multiply,
// rounding. A new request can be taken in every cycle; busy stays low.
// Reset clears the stage valid bits and loads the register reset values.
// The result side has no stall, so the pipeline never holds.
`default_nettype none

module heading_speed_command_generator_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire hscg_pkg::cmd_t                  cmd,
  output logic                                 done,
  output hscg_pkg::result_t                    result,
  input  wire logic                            cfg_write,
  input  wire logic [hscg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hscg_pkg::REG_W-1:0]      cfg_data
);

  localparam int WRAP_W = hscg_pkg::WRAP_W;
  localparam int MAG_W  = hscg_pkg::MAG_W;
  localparam int ARG_W  = hscg_pkg::ARG_W;
  localparam int IDX_W  = hscg_pkg::IDX_W;

  localparam logic signed [WRAP_W-1:0] PI_W     = WRAP_W'(hscg_pkg::PI_FIX);
  localparam logic signed [WRAP_W-1:0] TWO_PI_W = WRAP_W'(hscg_pkg::TWO_PI_FIX);

  // Configuration registers.
  logic [hscg_pkg::REG_W-1:0] recip_speed_width;
  logic [hscg_pkg::REG_W-1:0] recip_turn_width;
  logic [hscg_pkg::REG_W-1:0] max_linear_speed;
  logic [hscg_pkg::REG_W-1:0] max_turn_rate;

  // Pipeline registers.
  logic                            s1_valid;
  logic                            s1_neg;
  logic [MAG_W-1:0]                s1_mag;
  logic                            s2_valid;
  logic                            s2_neg;
  logic [ARG_W-1:0]                s2_arg_v;
  logic [ARG_W-1:0]                s2_arg_w;
  logic                            s3_valid;
  logic                            s3_neg;
  logic [hscg_pkg::GAUSS_W-1:0]    s3_gauss;
  logic [hscg_pkg::SIG_W-1:0]      s3_sig;
  logic                            s4_valid;
  logic                            s4_neg;
  logic [hscg_pkg::LIN_P_W-1:0]    s4_lin_p;
  logic [hscg_pkg::TURN_P_W-1:0]   s4_turn_p;

  // Combinational values between the stages.
  logic                            accept;
  logic signed [WRAP_W-1:0]        d_raw;
  logic signed [WRAP_W-1:0]        d_wrap;
  logic signed [WRAP_W-1:0]        d_abs;
  logic [ARG_W-1:0]                gauss_q;
  logic [ARG_W-1:0]                sig_q;
  logic [IDX_W-1:0]                gauss_idx;
  logic [IDX_W-1:0]                sig_idx;
  logic [hscg_pkg::LIN_P_W:0]      lin_round;
  logic [hscg_pkg::TURN_P_W:0]     turn_round;
  logic [hscg_pkg::LIN_P_W-16:0]   lin_full;
  logic [hscg_pkg::TURN_P_W-16:0]  turn_full;
  logic [15:0]                     lin_sat;
  logic [15:0]                     turn_sat;

  // The pipeline never stalls, so a request is always welcome.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      recip_speed_width <= hscg_pkg::RECIP_SPEED_WIDTH_RST;
      recip_turn_width  <= hscg_pkg::RECIP_TURN_WIDTH_RST;
      max_linear_speed  <= hscg_pkg::MAX_LINEAR_SPEED_RST;
      max_turn_rate     <= hscg_pkg::MAX_TURN_RATE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        hscg_pkg::REG_RECIP_SPEED_WIDTH: recip_speed_width <= cfg_data;
        hscg_pkg::REG_RECIP_TURN_WIDTH:  recip_turn_width  <= cfg_data;
        hscg_pkg::REG_MAX_LINEAR_SPEED:  max_linear_speed  <= cfg_data;
        hscg_pkg::REG_MAX_TURN_RATE:     max_turn_rate     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage one: heading error, wrapped once towards [-pi, pi], as sign and size.
  always_comb begin
    d_raw = WRAP_W'(cmd.target_angle) - WRAP_W'(cmd.heading);
    if (d_raw > PI_W) begin
      d_wrap = d_raw - TWO_PI_W;
    end else if (d_raw < -PI_W) begin
      d_wrap = d_raw + TWO_PI_W;
    end else begin
      d_wrap = d_raw;
    end
    d_abs = d_wrap[WRAP_W-1] ? -d_wrap : d_wrap;
  end

  // Stage two: scale the error size by each reciprocal shape constant.
  // Stage three: table index with clamp, then table lookup.
  always_comb begin
    gauss_q   = s2_arg_v >> hscg_pkg::GAUSS_SHIFT;
    sig_q     = s2_arg_w >> hscg_pkg::SIG_SHIFT;
    gauss_idx = (gauss_q > ARG_W'(hscg_pkg::LUT_DEPTH - 1)) ?
                IDX_W'(hscg_pkg::LUT_DEPTH - 1) : gauss_q[IDX_W-1:0];
    sig_idx   = (sig_q > ARG_W'(hscg_pkg::LUT_DEPTH - 1)) ?
                IDX_W'(hscg_pkg::LUT_DEPTH - 1) : sig_q[IDX_W-1:0];
  end

  // Stage five: round the products to the output scale and saturate.
  always_comb begin
    lin_round  = {1'b0, s4_lin_p} + (hscg_pkg::LIN_P_W + 1)'(32768);
    turn_round = {1'b0, s4_turn_p} + (hscg_pkg::TURN_P_W + 1)'(32768);
    lin_full   = lin_round[hscg_pkg::LIN_P_W:16];
    turn_full  = turn_round[hscg_pkg::TURN_P_W:16];
    lin_sat    = (lin_full > (hscg_pkg::LIN_P_W - 15)'(65535)) ?
                 16'hFFFF : lin_full[15:0];
    turn_sat   = (turn_full > (hscg_pkg::TURN_P_W - 15)'(32767)) ?
                 16'h7FFF : turn_full[15:0];
  end

  // Valid bits travel with the data down the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      done     <= s4_valid;
    end
  end

  // Payload registers of all stages.
  always_ff @(posedge clk) begin
    s1_neg    <= d_wrap[WRAP_W-1];
    s1_mag    <= d_abs[MAG_W-1:0];

    s2_neg    <= s1_neg;
    s2_arg_v  <= ARG_W'(s1_mag) * ARG_W'(recip_speed_width);
    s2_arg_w  <= ARG_W'(s1_mag) * ARG_W'(recip_turn_width);

    s3_neg    <= s2_neg;
    s3_gauss  <= hscg_pkg::GAUSS_LUT[gauss_idx];
    s3_sig    <= hscg_pkg::SIG_LUT[sig_idx];

    s4_neg    <= s3_neg;
    s4_lin_p  <= hscg_pkg::LIN_P_W'(max_linear_speed) * hscg_pkg::LIN_P_W'(s3_gauss);
    s4_turn_p <= hscg_pkg::TURN_P_W'(max_turn_rate) * hscg_pkg::TURN_P_W'(s3_sig);

    result.linear_speed <= lin_sat;
    result.turn_rate    <= s4_neg ? -$signed(turn_sat) : $signed(turn_sat);
  end

endmodule

`default_nettype wire

@@ hw/rtl/hscg_checker.sv @@
// Port-level checker for the heading speed command generator, bound to its top level.
`default_nettype none

module hscg_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              done,
  input wire hscg_pkg::result_t result
);

  // Every accepted request is followed by its result strobe.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##5 done)
    else $error("accepted request gave no result after five cycles");

  // No result appears without a matching earlier request.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 5))
    else $error("result strobe without a matching request");

  // The pipeline never refuses a request.
  a_never_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised although the pipeline cannot stall");

  // The cycle after reset carries no result.
  a_reset_quiet: assert property (@(posedge clk) (!rst && $past(rst)) |-> !done)
    else $error("result strobe straight after reset");

  // The turn rate is saturated to +/-32767, so the most negative code never shows.
  a_turn_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.turn_rate != 16'sh8000))
    else $error("turn rate outside its saturated range");

endmodule

bind heading_speed_command_generator_top hscg_checker u_hscg_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire
